// File: hdl/plist_pkg.sv
// Shared types, opcodes and tree sizing helpers for the positional list engine.
`default_nettype none

package plist_pkg;

  // Field widths of one transaction
  localparam int OP_W     = 3;
  localparam int POS_W    = 11;
  localparam int DATA_W   = 32;
  localparam int ST_W     = 2;
  localparam int CNT_O_W  = 11;

  // Fan-in of each node of the read reduction tree
  localparam int TREE_FAN = 8;

  // Opcodes
  localparam logic [OP_W-1:0] OP_READ   = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_HEAD   = 3'd2;
  localparam logic [OP_W-1:0] OP_TAIL   = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd4;

  // Status codes
  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] data_value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [ST_W-1:0]          status;
    logic [CNT_O_W-1:0]       element_count;
  } out_t;

  // Per-cycle command broadcast along the cell row
  typedef struct packed {
    logic ins;     // open a slot at the position and load the data
    logic del;     // close the slot at the position
    logic sample;  // capture the addressed element into the leaf register
  } ctl_t;

  // Node count of tree level lvl (level 0 is the row of leaves)
  function automatic int tree_size(input int n, input int lvl);
    int s;
    s = n;
    for (int i = 0; i < lvl; i++) begin
      s = (s + TREE_FAN - 1) / TREE_FAN;
    end
    return s;
  endfunction

  // Number of registered levels above the leaves
  function automatic int tree_levels(input int n);
    int s;
    int l;
    s = n;
    l = 0;
    while (s > 1) begin
      s = (s + TREE_FAN - 1) / TREE_FAN;
      l++;
    end
    return l;
  endfunction

  // Offset of level lvl (lvl >= 1) in the flat node store
  function automatic int tree_off(input int n, input int lvl);
    int o;
    o = 0;
    for (int i = 1; i < lvl; i++) begin
      o += tree_size(n, i);
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// File: hdl/plist_cell.sv
// One list cell: holds one element, shifts with its neighbours, captures a read leaf.
`default_nettype none

module plist_cell #(
  parameter int IDX = 0,
  parameter int PW  = 11
) (
  input  wire logic                                 clk_i,
  input  wire plist_pkg::ctl_t                      ctl_i,
  input  wire logic [PW-1:0]                        pos_i,
  input  wire logic signed [plist_pkg::DATA_W-1:0]  data_i,
  input  wire logic signed [plist_pkg::DATA_W-1:0]  left_i,
  input  wire logic signed [plist_pkg::DATA_W-1:0]  right_i,
  output logic signed [plist_pkg::DATA_W-1:0]       value_o,
  output logic signed [plist_pkg::DATA_W-1:0]       leaf_o
);

  localparam logic [PW-1:0] MY_POS = PW'(IDX);

  logic signed [plist_pkg::DATA_W-1:0] value_q, value_d;
  logic signed [plist_pkg::DATA_W-1:0] leaf_q, leaf_d;
  logic                                hit;

  assign hit = (pos_i == MY_POS);

  // Pick the next element: load, take from the left, take from the right, or hold
  always_comb begin
    value_d = value_q;
    priority if (ctl_i.ins && hit) begin
      value_d = data_i;
    end else if (ctl_i.ins && (MY_POS > pos_i)) begin
      value_d = left_i;
    end else if (ctl_i.del && (MY_POS >= pos_i)) begin
      value_d = right_i;
    end else begin
      value_d = value_q;
    end
  end

  // Present the element to the tree only when this cell is addressed
  always_comb begin
    leaf_d = leaf_q;
    if (ctl_i.sample) begin
      leaf_d = hit ? value_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    leaf_q  <= leaf_d;
  end

  assign value_o = value_q;
  assign leaf_o  = leaf_q;

endmodule

`default_nettype wire

// File: hdl/plist_or_tree.sv
// Registered OR reduction tree that gathers the one addressed leaf to a root.
`default_nettype none

module plist_or_tree #(
  parameter int N = 1024,
  parameter int W = 32
) (
  input  wire logic         clk_i,
  input  wire logic [W-1:0] leaf_i [N],
  output logic [W-1:0]      root_o
);

  localparam int FAN    = plist_pkg::TREE_FAN;
  localparam int LEVELS = plist_pkg::tree_levels(N);
  localparam int TOTAL  = plist_pkg::tree_off(N, LEVELS + 1);

  logic [W-1:0] node_q [TOTAL];

  for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
    localparam int SZ   = plist_pkg::tree_size(N, l);
    localparam int PSZ  = plist_pkg::tree_size(N, l - 1);
    localparam int OFF  = plist_pkg::tree_off(N, l);
    localparam int POFF = plist_pkg::tree_off(N, l - 1);

    for (genvar j = 0; j < SZ; j++) begin : g_node
      logic [FAN-1:0][W-1:0] term;
      logic [W-1:0]          acc;

      // Gather the children of this node
      for (genvar k = 0; k < FAN; k++) begin : g_child
        if (j * FAN + k >= PSZ) begin : g_pad
          assign term[k] = '0;
        end else if (l == 1) begin : g_leaf
          assign term[k] = leaf_i[j * FAN + k];
        end else begin : g_inner
          assign term[k] = node_q[POFF + j * FAN + k];
        end
      end

      always_comb begin
        acc = '0;
        for (int k = 0; k < FAN; k++) begin
          acc = acc | term[k];
        end
      end

      always_ff @(posedge clk_i) begin
        node_q[OFF + j] <= acc;
      end
    end
  end

  assign root_o = node_q[TOTAL - 1];

endmodule

`default_nettype wire

// File: hdl/positional_list_engine_top.sv
// Positional list engine: a row of shifting cells with a registered read tree.
// An accepted transaction is sampled into the leaf registers and climbs the L registered levels of
//   the read reduction tree, where L = ceil(log8(CAPACITY)) (4 for 1024), before its result is registered.
// A new transaction is taken only after the result of the last one is loaded, so one is in flight at a time.
// Inserts and deletes shift the cells from the addressed position upward in the cycle of acceptance.
// Reset clears the element count and the handshake state; element contents are not cleared.
`default_nettype none

module positional_list_engine_top #(
  parameter int CAPACITY = 1024
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire plist_pkg::in_t   in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output plist_pkg::out_t       out_data_o
);

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int WW     = (CW > plist_pkg::POS_W) ? CW : plist_pkg::POS_W;
  localparam int LEVELS = plist_pkg::tree_levels(CAPACITY);
  localparam int LVW    = $clog2(LEVELS + 1);
  localparam int DW     = plist_pkg::DATA_W;

  // Control state
  logic           busy_q, busy_d;
  logic [LVW-1:0] lvl_q, lvl_d;
  logic [CW-1:0]  count_q, count_d;
  logic           out_valid_q, out_valid_d;

  // Held result of the transaction in flight
  logic                          rd_hit_q, is_read_q;
  logic [plist_pkg::ST_W-1:0]    st_q;
  logic [CW-1:0]                 cnt_res_q;
  plist_pkg::out_t               out_q, out_d;

  // Decode
  logic                       acc_in;
  logic                       done, load_out;
  logic [WW-1:0]              posx, cntx;
  logic                       full;
  logic                       do_ins, do_del, rd_hit, is_read;
  logic [plist_pkg::ST_W-1:0] st;
  logic [CW-1:0]              cell_pos;
  plist_pkg::ctl_t            ctl;

  // Row and tree
  logic signed [DW-1:0] cell_val [CAPACITY];
  logic [DW-1:0]        leaf     [CAPACITY];
  logic [DW-1:0]        root;

  assign acc_in = in_valid_i && !busy_q;
  assign posx   = WW'(in_data_i.position);
  assign cntx   = WW'(count_q);
  assign full   = (count_q == CW'(CAPACITY));

  // Decode the opcode against the current count
  always_comb begin
    do_ins   = 1'b0;
    do_del   = 1'b0;
    rd_hit   = 1'b0;
    is_read  = 1'b0;
    st       = plist_pkg::ST_DONE;
    cell_pos = CW'(in_data_i.position);
    unique case (in_data_i.opcode)
      plist_pkg::OP_READ: begin
        is_read = 1'b1;
        if (posx < cntx) begin
          rd_hit = 1'b1;
        end else begin
          st = plist_pkg::ST_RANGE;
        end
      end
      plist_pkg::OP_INSERT: begin
        priority if (posx > cntx) begin
          st = plist_pkg::ST_RANGE;
        end else if (full) begin
          st = plist_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      plist_pkg::OP_HEAD: begin
        cell_pos = '0;
        if (full) begin
          st = plist_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      plist_pkg::OP_TAIL: begin
        cell_pos = count_q;
        if (full) begin
          st = plist_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      plist_pkg::OP_DELETE: begin
        if (posx < cntx) begin
          do_del = 1'b1;
        end else begin
          st = plist_pkg::ST_RANGE;
        end
      end
      default: begin
        st = plist_pkg::ST_RANGE;
      end
    endcase
  end

  assign ctl.ins    = acc_in && do_ins;
  assign ctl.del    = acc_in && do_del;
  assign ctl.sample = acc_in;

  // Cell row: each cell takes from its neighbours on a shift
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DW-1:0] left_v, right_v;

    if (i == 0) begin : g_first
      assign left_v = cell_val[i];
    end else begin : g_mid_l
      assign left_v = cell_val[i - 1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = cell_val[i];
    end else begin : g_mid_r
      assign right_v = cell_val[i + 1];
    end

    plist_cell #(
      .IDX (i),
      .PW  (CW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .pos_i   (cell_pos),
      .data_i  (in_data_i.data_value),
      .left_i  (left_v),
      .right_i (right_v),
      .value_o (cell_val[i]),
      .leaf_o  (leaf[i])
    );
  end

  plist_or_tree #(
    .N (CAPACITY),
    .W (DW)
  ) u_tree (
    .clk_i  (clk_i),
    .leaf_i (leaf),
    .root_o (root)
  );

  assign done     = busy_q && (lvl_q == '0);
  assign load_out = done && (!out_valid_q || !out_stall_i);

  // Advance the count, the tree countdown and the output handshake
  always_comb begin
    count_d     = count_q;
    busy_d      = busy_q;
    lvl_d       = lvl_q;
    out_valid_d = out_valid_q;
    if (ctl.ins) begin
      count_d = count_q + CW'(1);
    end else if (ctl.del) begin
      count_d = count_q - CW'(1);
    end
    if (acc_in) begin
      busy_d = 1'b1;
      lvl_d  = LVW'(LEVELS);
    end else if (load_out) begin
      busy_d = 1'b0;
    end else if (busy_q && (lvl_q != '0)) begin
      lvl_d = lvl_q - LVW'(1);
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Build the result once the root holds the addressed element
  always_comb begin
    out_d = out_q;
    if (load_out) begin
      out_d.status        = st_q;
      out_d.element_count = plist_pkg::CNT_O_W'(cnt_res_q);
      if (rd_hit_q) begin
        out_d.read_value = root;
      end else if (is_read_q) begin
        out_d.read_value = -32'sd1;
      end else begin
        out_d.read_value = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      lvl_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      lvl_q       <= lvl_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the decoded result fields of the transaction in flight
  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      rd_hit_q  <= rd_hit;
      is_read_q <= is_read;
      st_q      <= st;
      cnt_res_q <= count_d;
    end
    out_q <= out_d;
  end

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // An accepted transaction keeps the engine busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_in |=> busy_q)
    else $error("engine not busy after accepting a transaction");

  // The count never passes the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("element count above capacity");

  // A new result appears only when the tree has finished
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(done))
    else $error("result raised before the tree finished");

  // A refused or out-of-range transaction leaves the count alone
  a_refused_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_in && (st != plist_pkg::ST_DONE)) |=> $stable(count_q))
    else $error("count changed on a refused transaction");

  // The engine never finishes without a transaction in flight
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> busy_q)
    else $error("result loaded while idle");

endmodule

`default_nettype wire
